### design/vtp_pkg.sv
package vtp_pkg;

    // Default fixed-point format and screen range.
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SCREEN_BITS_DEF = 16;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_XFORM   = 2'd1;
    localparam logic [1:0] FUNC_PROJECT = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;

    // Reset values of the screen offsets.
    localparam logic signed [15:0] CENTER_X_RST = 16'sd160;
    localparam logic signed [15:0] CENTER_Y_RST = 16'sd128;

    // Quotient bits resolved by the divider. A quotient magnitude at or above
    // 2^QUO_BITS saturates the screen coordinate no matter what the 16-bit
    // center is, so higher bits are replaced by an overflow flag.
    localparam int QUO_BITS = 18;

    // Result fields that ride along the divider unchanged.
    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic        proj;
        logic        fault;
        logic        last;
        logic [1:0]  neg;
    } pass_t;

endpackage

### design/vertex_transform_project_core.sv
// Channel   Direction  Signals                                   Transfer
// s_axis    in         tvalid tready tdata[135:0] tuser tlast     one vertex or matrix load
// m_axis    out        tvalid tready tdata[127:0] tuser tlast     one transformed vertex
// cfg       in         valid ready index data[15:0]               one center register write
//
// Stages: a vertex passes through 7 + QUO_BITS register stages (25 by default):
// operand capture, nine 32x32 multiplies, column sum, scale and offset, magnitude
// split, divider overflow check, one quotient bit per stage, then the screen fixup.
// One transfer per cycle unless stalled; matrix loads take effect at once and
// occupy no stage. Reset loads the identity matrix and the default centers and
// empties the pipeline. A stall on m_axis holds only the stages that are full; a
// bubble further up still fills, so nothing is lost or repeated.
module vertex_transform_project_core #(
    parameter int FRAC_BITS   = vtp_pkg::FRAC_BITS_DEF,
    parameter int SCREEN_BITS = vtp_pkg::SCREEN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // row[1:0], col[3:2], coeff[35:4], vx[67:36], vy[99:68], vz[131:100], zero pad
    input  logic [135:0]                  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                    s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], screen_x[111:96], screen_y[127:112]
    output logic [127:0]                  m_axis_tdata,
    // divide_fault[0]
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    localparam int QB    = vtp_pkg::QUO_BITS;
    // Column sums fit in this many signed bits after scaling and offset.
    localparam int COL_W = 67 - FRAC_BITS;
    localparam int DW    = COL_W + QB;
    localparam int SW    = QB + 2;
    localparam int NST   = 7 + QB;
    localparam int ST_F  = 5;
    localparam int ST_O  = NST - 1;
    localparam logic signed [SW-1:0] SCR_HI = SW'((64'sd1 <<< (SCREEN_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SCR_LO = SW'(-(64'sd1 <<< (SCREEN_BITS - 1)));

    // Input fields.
    logic [1:0]         in_func;
    logic [3:0]         in_addr;
    logic signed [31:0] in_coeff;
    logic signed [31:0] in_vx;
    logic signed [31:0] in_vy;
    logic signed [31:0] in_vz;
    logic               in_take;

    assign in_func  = s_axis_tuser;
    assign in_addr  = {s_axis_tdata[1:0], s_axis_tdata[3:2]};
    assign in_coeff = s_axis_tdata[35:4];
    assign in_vx    = s_axis_tdata[67:36];
    assign in_vy    = s_axis_tdata[99:68];
    assign in_vz    = s_axis_tdata[131:100];
    assign in_take  = s_axis_tvalid && s_axis_tready;

    // Configuration: always ready, indexes beyond the register list are dropped.
    logic signed [15:0] center_x_reg;
    logic signed [15:0] center_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= vtp_pkg::CENTER_X_RST;
            center_y_reg <= vtp_pkg::CENTER_Y_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == vtp_pkg::CFG_CENTER_X)
                center_x_reg <= cfg_data;
            else if (cfg_index == vtp_pkg::CFG_CENTER_Y)
                center_y_reg <= cfg_data;
        end
    end

    // Pipeline flow control. A stage advances when it is empty or the stage
    // below it advances; valid bits travel with the payload.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_take && (in_func == vtp_pkg::FUNC_XFORM ||
                                        in_func == vtp_pkg::FUNC_PROJECT);
            for (int i = 1; i < NST; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Matrix store, written by load transfers as they are accepted. A vertex
    // captures its coefficients in the same cycle, so it sees every earlier load.
    logic signed [31:0] mat_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
        end
        else if (in_take && in_func == vtp_pkg::FUNC_LOAD)
            mat_reg[in_addr] <= in_coeff;
    end

    // Stage A: operands. Column slot 2 holds matrix column 2 for a transform
    // and column 3 (the homogeneous w) for a projection.
    logic signed [31:0] a_v_reg [3];
    logic signed [31:0] a_m_reg [4][3];
    logic               a_proj_reg;
    logic               a_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_v_reg[0] <= in_vx;
            a_v_reg[1] <= in_vy;
            a_v_reg[2] <= in_vz;
            for (int r = 0; r < 4; r++)
            begin
                a_m_reg[r][0] <= mat_reg[r*4];
                a_m_reg[r][1] <= mat_reg[r*4+1];
                a_m_reg[r][2] <= (in_func == vtp_pkg::FUNC_PROJECT) ?
                                 mat_reg[r*4+3] : mat_reg[r*4+2];
            end
            a_proj_reg <= (in_func == vtp_pkg::FUNC_PROJECT);
            a_last_reg <= s_axis_tlast;
        end
    end

    // Stage B: the nine products, full width.
    logic signed [63:0] b_p_reg [3][3];
    logic signed [31:0] b_m3_reg [3];
    logic               b_proj_reg;
    logic               b_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                    b_p_reg[c][r] <= a_m_reg[r][c] * a_v_reg[r];
                b_m3_reg[c] <= a_m_reg[3][c];
            end
            b_proj_reg <= a_proj_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // Stage C: exact column sums.
    logic signed [65:0] c_sum_reg [3];
    logic signed [31:0] c_m3_reg [3];
    logic               c_proj_reg;
    logic               c_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                c_sum_reg[c] <= {{2{b_p_reg[c][0][63]}}, b_p_reg[c][0]}
                              + {{2{b_p_reg[c][1][63]}}, b_p_reg[c][1]}
                              + {{2{b_p_reg[c][2][63]}}, b_p_reg[c][2]};
                c_m3_reg[c] <= b_m3_reg[c];
            end
            c_proj_reg <= b_proj_reg;
            c_last_reg <= b_last_reg;
        end
    end

    // Stage D: floor scaling back to the fixed-point format plus the row 3 term.
    logic signed [COL_W-1:0] d_col_reg [3];
    logic                    d_proj_reg;
    logic                    d_last_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int c = 0; c < 3; c++)
                d_col_reg[c] <= COL_W'(c_sum_reg[c] >>> FRAC_BITS)
                              + {{(COL_W-32){c_m3_reg[c][31]}}, c_m3_reg[c]};
            d_proj_reg <= c_proj_reg;
            d_last_reg <= c_last_reg;
        end
    end

    // Stage E: saturated results, divider magnitudes, quotient signs and the divide fault flag.
    function automatic logic [31:0] sat32(input logic signed [COL_W-1:0] v);
        logic hi_same;
        hi_same = (v[COL_W-1:31] == '0) || (v[COL_W-1:31] == '1);
        if (hi_same)
            return v[31:0];
        else if (v[COL_W-1])
            return 32'h8000_0000;
        else
            return 32'h7fff_ffff;
    endfunction

    function automatic logic [COL_W-1:0] mag(input logic signed [COL_W-1:0] v);
        return v[COL_W-1] ? COL_W'(-v) : COL_W'(v);
    endfunction

    vtp_pkg::pass_t   e_pass_reg;
    logic [COL_W-1:0] e_num_reg [2];
    logic [COL_W-1:0] e_den_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            e_pass_reg.ox    <= sat32(d_col_reg[0]);
            e_pass_reg.oy    <= sat32(d_col_reg[1]);
            e_pass_reg.oz    <= sat32(d_col_reg[2]);
            e_pass_reg.proj  <= d_proj_reg;
            e_pass_reg.fault <= d_proj_reg && (d_col_reg[2] == '0);
            e_pass_reg.last  <= d_last_reg;
            e_pass_reg.neg   <= {d_col_reg[1][COL_W-1] ^ d_col_reg[2][COL_W-1],
                                 d_col_reg[0][COL_W-1] ^ d_col_reg[2][COL_W-1]};
            e_num_reg[0]     <= mag(d_col_reg[0]);
            e_num_reg[1]     <= mag(d_col_reg[1]);
            e_den_reg        <= mag(d_col_reg[2]);
        end
    end

    // Divider: entry 0 is the overflow check stage, entry k has resolved k
    // quotient bits, most significant first. Lane 0 is x, lane 1 is y.
    logic [COL_W-1:0]  rem_reg [QB+1][2];
    logic [QB-1:0]     quo_reg [QB+1][2];
    logic              ovf_reg [QB+1][2];
    logic [COL_W-1:0]  den_reg [QB+1];
    vtp_pkg::pass_t    pass_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_F])
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= e_num_reg[l];
                quo_reg[0][l] <= '0;
                ovf_reg[0][l] <= {{QB{1'b0}}, e_num_reg[l]} >= {e_den_reg, {QB{1'b0}}};
            end
            den_reg[0]  <= e_den_reg;
            pass_reg[0] <= e_pass_reg;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_div
        localparam int BIT = QB - k;
        logic [DW-1:0] dsh;
        logic          ge [2];

        assign dsh = {{QB{1'b0}}, den_reg[k-1]} << BIT;

        always_comb
        begin
            for (int l = 0; l < 2; l++)
                ge[l] = {{QB{1'b0}}, rem_reg[k-1][l]} >= dsh;
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_F + k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= ge[l] ? rem_reg[k-1][l] - dsh[COL_W-1:0]
                                           : rem_reg[k-1][l];
                    // The bit resolved here is still zero in the incoming quotient.
                    quo_reg[k][l] <= quo_reg[k-1][l]
                                   | ({{(QB-1){1'b0}}, ge[l]} << BIT);
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
                den_reg[k]  <= den_reg[k-1];
                pass_reg[k] <= pass_reg[k-1];
            end
        end
    end

    // Output stage: signed quotient plus center, truncated toward zero and
    // saturated to the screen range. The fractional part has the quotient's
    // sign, so a nonzero remainder pulls the sum one step toward zero only
    // when the sum and the fraction have opposite signs.
    logic [15:0] scr_next [2];

    always_comb
    begin
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] s;
        logic signed [15:0]   cen;
        logic                 neg;
        for (int l = 0; l < 2; l++)
        begin
            neg = pass_reg[QB].neg[l];
            cen = (l == 0) ? center_x_reg : center_y_reg;
            qs  = neg ? -$signed({2'b00, quo_reg[QB][l]}) : $signed({2'b00, quo_reg[QB][l]});
            s   = qs + {{(SW-16){cen[15]}}, cen};
            if (rem_reg[QB][l] != '0)
            begin
                if (s > 0 && neg)
                    s = s - SW'(1);
                else if (s < 0 && !neg)
                    s = s + SW'(1);
            end
            if (ovf_reg[QB][l])
                s = neg ? SCR_LO : SCR_HI;
            else if (s > SCR_HI)
                s = SCR_HI;
            else if (s < SCR_LO)
                s = SCR_LO;
            scr_next[l] = (pass_reg[QB].proj && !pass_reg[QB].fault) ? s[15:0] : 16'd0;
        end
    end

    vtp_pkg::pass_t out_pass_reg;
    logic [15:0]    out_sx_reg;
    logic [15:0]    out_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_O])
        begin
            out_pass_reg <= pass_reg[QB];
            out_sx_reg   <= scr_next[0];
            out_sy_reg   <= scr_next[1];
        end
    end

    assign m_axis_tvalid = v_reg[ST_O];
    assign m_axis_tdata  = {out_sy_reg, out_sx_reg, out_pass_reg.oz,
                            out_pass_reg.oy, out_pass_reg.ox};
    assign m_axis_tuser  = out_pass_reg.fault;
    assign m_axis_tlast  = out_pass_reg.last;

endmodule
